// ===== sv/text_console_writer_macros.svh =====
// ----------------------------------------------------------------------------
// text_console_writer_macros.svh
// Assertion shorthands shared by the console checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Checked on aclk, idle while reset is asserted.
`define TCW_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("console check failed");

// Checked on aclk, also while reset is asserted.
`define TCW_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("console check failed during reset");

`endif

// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Geometry, codes and shared types of the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int NUM_CELLS = ROWS * COLUMNS;
    localparam int SCROLL_CELLS = NUM_CELLS - COLUMNS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(NUM_CELLS);

    // Fixed field widths of the stream items
    localparam int KIND_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_POS_W  = 11;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = CHAR_W + ATTR_W;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'd13;

    localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;

    // Screen store access, one write and one read port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [OUT_COL_W-1:0] cursor_column;
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [OUT_POS_W-1:0] cursor_position;
        logic [CHAR_W-1:0]    read_char;
        logic [ATTR_W-1:0]    read_attribute;
        logic                 scrolled;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/tcw_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram (
    input  wire logic                          aclk,
    input  wire tcw_pkg::mem_req_t             req,
    output logic [tcw_pkg::CELL_W-1:0]         rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::NUM_CELLS];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Request sequencer: cursor, attribute, scroll copy and blank fill sweeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tcw_pkg::ATTR_W-1:0]    cfg_wr_data,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic [tcw_pkg::KIND_W-1:0]    req_kind,
    input  wire logic [tcw_pkg::CHAR_W-1:0]    req_char,
    input  wire logic [tcw_pkg::INDEX_W-1:0]   req_index,
    output tcw_pkg::result_t                   res,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output tcw_pkg::mem_req_t                  mem_req,
    input  wire logic [tcw_pkg::CELL_W-1:0]    mem_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCROLL = 4'b0010,
        ST_FILL   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    localparam logic [tcw_pkg::ADDR_W-1:0] CNT_LAST   = tcw_pkg::ADDR_W'(tcw_pkg::NUM_CELLS - 1);
    localparam logic [tcw_pkg::ADDR_W-1:0] CNT_SCROLL = tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_CELLS);
    localparam logic [tcw_pkg::COL_W-1:0]  COL_LAST   = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
    localparam logic [tcw_pkg::ROW_W-1:0]  ROW_LAST   = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

    state_t                         state_reg, state_next;
    logic [tcw_pkg::ADDR_W-1:0]     cnt_reg, cnt_next;
    logic [tcw_pkg::COL_W-1:0]      col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [tcw_pkg::ATTR_W-1:0]     attr_reg, attr_next;
    logic                           report_reg, report_next;
    logic                           scrolled_reg, scrolled_next;
    logic                           rd_hit_reg, rd_hit_next;
    logic                           wr_pend_reg, wr_pend_next;
    logic [tcw_pkg::ADDR_W-1:0]     wr_addr_reg, wr_addr_next;

    logic                           accept;
    logic [tcw_pkg::ADDR_W-1:0]     cursor_addr;

    assign accept      = req_valid && (state_reg == ST_IDLE);
    assign req_ready   = (state_reg == ST_IDLE);
    assign cursor_addr = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(row_reg) *
                                          tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS))
                         + tcw_pkg::ADDR_W'(col_reg);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        attr_next     = cfg_wr_en ? cfg_wr_data : attr_reg;
        report_next   = report_reg;
        scrolled_next = scrolled_reg;
        rd_hit_next   = rd_hit_reg;
        wr_pend_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        mem_req       = '0;
        res_valid     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    scrolled_next = 1'b0;
                    rd_hit_next   = 1'b0;
                    state_next    = ST_DONE;
                    case (req_kind)
                        tcw_pkg::KIND_PUT: begin
                            logic next_line;
                            next_line = 1'b0;
                            if (req_char == tcw_pkg::CHAR_NEWLINE) begin
                                col_next  = '0;
                                next_line = 1'b1;
                            end else if (req_char == tcw_pkg::CHAR_RETURN) begin
                                col_next = '0;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = cursor_addr;
                                mem_req.wdata = {attr_reg, req_char};
                                if (col_reg == COL_LAST) begin
                                    col_next  = '0;
                                    next_line = 1'b1;
                                end else begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                            if (next_line) begin
                                if (row_reg == ROW_LAST) begin
                                    // cursor stays on the last row, store moves up
                                    scrolled_next = 1'b1;
                                    cnt_next      = '0;
                                    report_next   = 1'b1;
                                    state_next    = ST_SCROLL;
                                end else begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                        end
                        tcw_pkg::KIND_CLEAR: begin
                            col_next    = '0;
                            row_next    = '0;
                            cnt_next    = '0;
                            report_next = 1'b1;
                            state_next  = ST_FILL;
                        end
                        tcw_pkg::KIND_READ: begin
                            if (req_index < tcw_pkg::INDEX_W'(tcw_pkg::NUM_CELLS)) begin
                                rd_hit_next   = 1'b1;
                                mem_req.re    = 1'b1;
                                mem_req.raddr = tcw_pkg::ADDR_W'(req_index);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCROLL: begin
                // read cell cnt+COLUMNS, write it to cell cnt in the next cycle
                if (wr_pend_reg) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = wr_addr_reg;
                    mem_req.wdata = mem_rdata;
                end
                if (cnt_reg == CNT_SCROLL) begin
                    state_next = ST_FILL;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = cnt_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                    wr_pend_next  = 1'b1;
                    wr_addr_next  = cnt_reg;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end

            ST_FILL: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg;
                mem_req.wdata = tcw_pkg::BLANK_CELL;
                if (cnt_reg == CNT_LAST) begin
                    state_next = report_reg ? ST_DONE : ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.cursor_column   = tcw_pkg::OUT_COL_W'(col_reg);
        res.cursor_row      = tcw_pkg::OUT_ROW_W'(row_reg);
        res.cursor_position = tcw_pkg::OUT_POS_W'(cursor_addr);
        res.read_char       = rd_hit_reg ? mem_rdata[tcw_pkg::CHAR_W-1:0] : '0;
        res.read_attribute  = rd_hit_reg ? mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
        res.scrolled        = scrolled_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // reset starts a blank sweep of the whole store
            state_reg    <= ST_FILL;
            cnt_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            attr_reg     <= tcw_pkg::ATTR_DEFAULT;
            report_reg   <= 1'b0;
            scrolled_reg <= 1'b0;
            rd_hit_reg   <= 1'b0;
            wr_pend_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            attr_reg     <= attr_next;
            report_reg   <= report_next;
            scrolled_reg <= scrolled_next;
            rd_hit_reg   <= rd_hit_next;
            wr_pend_reg  <= wr_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg <= wr_addr_next;
    end

endmodule

`default_nettype wire

// ===== sv/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console: screen store, cursor, scroll and clear.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: tuser is the kind (put, clear, read), tdata the
//   character byte and the linear cell index of a read. m_* returns one
//   result per request: cursor column, row and linear position, the read
//   cell, and tuser flags a put that scrolled the screen.
//   cfg_wr_en / cfg_wr_data set the attribute stored with put characters.
// Timing:
//   Put, read and unused kinds go from the request cycle to the result, which
//   is then loaded into the output register. A put that scrolls adds a copy
//   sweep that moves the screen up by one row, then a blank fill of the last
//   row. A clear adds a blank sweep of all ROWS*COLUMNS cells. Each sweep
//   goes through the single write port of the screen store.
// Reset:
//   The cursor homes, the attribute returns to 0x0F and a blank sweep of all
//   ROWS*COLUMNS cells runs with s_tready low.
// Stall:
//   A result waits in the output register while m_tready is low; the next
//   request is still taken and worked on, and only its result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [7:0]   cfg_wr_data,    // text_attribute
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,        // char_code, cell_index, zero pad
    input  wire logic [1:0]   s_tuser,        // kind
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata,        // cursor_column, cursor_row,
                                              // cursor_position, read_char,
                                              // read_attribute, zero pad
    output logic              m_tuser         // scrolled
);

    tcw_pkg::mem_req_t             mem_req;
    logic [tcw_pkg::CELL_W-1:0]    mem_rdata;
    tcw_pkg::result_t              res;
    logic                          res_valid;
    logic                          slot_free;

    logic                          m_valid_reg, m_valid_next;
    tcw_pkg::result_t              m_res_reg;

    assign slot_free = !m_valid_reg || m_tready;

    tcw_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_kind    (s_tuser),
        .req_char    (s_tdata[7:0]),
        .req_index   (s_tdata[18:8]),
        .res         (res),
        .res_valid   (res_valid),
        .res_ready   (slot_free),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    tcw_screen_ram u_ram (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (slot_free) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0,
                       m_res_reg.read_attribute,
                       m_res_reg.read_char,
                       m_res_reg.cursor_position,
                       m_res_reg.cursor_row,
                       m_res_reg.cursor_column};
    assign m_tuser  = m_res_reg.scrolled;

endmodule

`default_nettype wire

// ===== sv/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_writer_macros.svh"

module tcw_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tready,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [39:0]  m_tdata,
    input  wire logic         m_tuser
);

    logic [tcw_pkg::OUT_COL_W-1:0] col;
    logic [tcw_pkg::OUT_ROW_W-1:0] row;
    logic [tcw_pkg::OUT_POS_W-1:0] pos;

    assign col = m_tdata[6:0];
    assign row = m_tdata[11:7];
    assign pos = m_tdata[22:12];

    // stalled result holds
    `TCW_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // store is swept after reset before any request is taken
    `TCW_ASSERT_ALWAYS(a_reset_sweep, !aresetn |=> !s_tready)

    // a scrolling put leaves the cursor on the last row
    `TCW_ASSERT(a_scroll_row, m_tvalid && m_tuser |-> row == tcw_pkg::OUT_ROW_W'(tcw_pkg::ROWS - 1))

    // cursor column stays on screen and its linear position agrees with row and column
    `TCW_ASSERT(a_cursor, m_tvalid |-> col < tcw_pkg::OUT_COL_W'(tcw_pkg::COLUMNS) && pos == tcw_pkg::OUT_POS_W'(tcw_pkg::OUT_POS_W'(row) * tcw_pkg::OUT_POS_W'(tcw_pkg::COLUMNS) + tcw_pkg::OUT_POS_W'(col)))

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/text_console_writer_test.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_test
// Self-checking bench for the text console writer: a short table of put,
// clear, read and unused requests, most with hand-worked results, then four
// phases of random traffic under different sender idling and back-pressure,
// each under a new text attribute. Every result is checked field by field
// against its hand-worked value or a shadow of the screen store and cursor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_test;

    localparam logic [tcw_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int PHASE_REQUESTS = 450;

    typedef struct {
        logic [tcw_pkg::KIND_W-1:0]  kind;
        logic [tcw_pkg::CHAR_W-1:0]  char_code;
        logic [tcw_pkg::INDEX_W-1:0] cell_index;
        bit                          hand_worked;
        tcw_pkg::result_t            want;
    } table_row_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    // shadow of the block
    logic [tcw_pkg::CELL_W-1:0]    screen_shadow [tcw_pkg::NUM_CELLS];
    logic [tcw_pkg::OUT_COL_W-1:0] cursor_col;
    logic [tcw_pkg::OUT_ROW_W-1:0] cursor_row;
    logic [tcw_pkg::ATTR_W-1:0]    attr_shadow;

    tcw_pkg::result_t pending_reports [$];
    table_row_t       directed_rows [$];
    int               mismatch_count = 0;
    int               sender_idle_pct = 0;
    int               receiver_stall_pct = 0;

    text_console_writer u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #150_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic void blank_screen();
        for (int i = 0; i < tcw_pkg::NUM_CELLS; i++) begin
            screen_shadow[i] = tcw_pkg::BLANK_CELL;
        end
    endfunction

    // Applies one request to the shadow and returns the report it should give.
    function automatic tcw_pkg::result_t apply_console_request(
            input logic [tcw_pkg::KIND_W-1:0] kind,
            input logic [tcw_pkg::CHAR_W-1:0] char_code,
            input logic [tcw_pkg::INDEX_W-1:0] cell_index);
        tcw_pkg::result_t r;
        r = '0;
        case (kind)
            tcw_pkg::KIND_PUT: begin
                if (char_code == tcw_pkg::CHAR_NEWLINE) begin
                    cursor_col = '0;
                    cursor_row = cursor_row + 1'b1;
                end else if (char_code == tcw_pkg::CHAR_RETURN) begin
                    cursor_col = '0;
                end else begin
                    screen_shadow[tcw_pkg::ADDR_W'(cursor_row * tcw_pkg::COLUMNS + cursor_col)]
                        = {attr_shadow, char_code};
                    cursor_col = cursor_col + 1'b1;
                    if (cursor_col >= tcw_pkg::COLUMNS) begin
                        cursor_col = '0;
                        cursor_row = cursor_row + 1'b1;
                    end
                end
                if (cursor_row >= tcw_pkg::ROWS) begin
                    for (int i = 0; i < tcw_pkg::SCROLL_CELLS; i++) begin
                        screen_shadow[i] = screen_shadow[i + tcw_pkg::COLUMNS];
                    end
                    for (int i = tcw_pkg::SCROLL_CELLS; i < tcw_pkg::NUM_CELLS; i++) begin
                        screen_shadow[i] = tcw_pkg::BLANK_CELL;
                    end
                    cursor_row = tcw_pkg::OUT_ROW_W'(tcw_pkg::ROWS - 1);
                    r.scrolled = 1'b1;
                end
            end
            tcw_pkg::KIND_CLEAR: begin
                blank_screen();
                cursor_col = '0;
                cursor_row = '0;
            end
            tcw_pkg::KIND_READ: begin
                if (cell_index < tcw_pkg::NUM_CELLS) begin
                    {r.read_attribute, r.read_char} = screen_shadow[cell_index];
                end
            end
            default: ;
        endcase
        r.cursor_column   = cursor_col;
        r.cursor_row      = cursor_row;
        r.cursor_position = tcw_pkg::OUT_POS_W'(cursor_row * tcw_pkg::COLUMNS + cursor_col);
        return r;
    endfunction

    function automatic void add_row(input logic [tcw_pkg::KIND_W-1:0] kind, input int char_code,
                                    input int cell_index, input bit hand_worked,
                                    input int col, input int row, input int pos,
                                    input int rchar, input int rattr);
        table_row_t t;
        t.kind        = kind;
        t.char_code   = tcw_pkg::CHAR_W'(char_code);
        t.cell_index  = tcw_pkg::INDEX_W'(cell_index);
        t.hand_worked = hand_worked;
        t.want        = '0;
        t.want.cursor_column   = tcw_pkg::OUT_COL_W'(col);
        t.want.cursor_row      = tcw_pkg::OUT_ROW_W'(row);
        t.want.cursor_position = tcw_pkg::OUT_POS_W'(pos);
        t.want.read_char       = tcw_pkg::CHAR_W'(rchar);
        t.want.read_attribute  = tcw_pkg::ATTR_W'(rattr);
        directed_rows.push_back(t);
    endfunction

    task automatic write_attribute(input logic [tcw_pkg::ATTR_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        attr_shadow = value;
    endtask

    // Presents one request, waits for it to be taken, records the report due.
    task automatic send_request(input logic [tcw_pkg::KIND_W-1:0] kind,
                                input logic [tcw_pkg::CHAR_W-1:0] char_code,
                                input logic [tcw_pkg::INDEX_W-1:0] cell_index,
                                input bit hand_worked, input tcw_pkg::result_t want);
        tcw_pkg::result_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, cell_index, char_code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_console_request(kind, char_code, cell_index);
        pending_reports.push_back(hand_worked ? want : predicted);
    endtask

    task automatic random_request(output logic [tcw_pkg::KIND_W-1:0] kind,
                                  output logic [tcw_pkg::CHAR_W-1:0] char_code,
                                  output logic [tcw_pkg::INDEX_W-1:0] cell_index);
        int pick;
        pick       = $urandom_range(0, 999);
        char_code  = tcw_pkg::CHAR_W'($urandom_range(0, 255));
        cell_index = tcw_pkg::INDEX_W'($urandom_range(0, 2047));
        if (pick < 1) begin
            kind = tcw_pkg::KIND_CLEAR;
        end else if (pick < 20) begin
            kind = KIND_UNUSED;
        end else if (pick < 140) begin
            kind = tcw_pkg::KIND_READ;
            if ($urandom_range(0, 9) != 0) begin
                cell_index = tcw_pkg::INDEX_W'($urandom_range(0, tcw_pkg::NUM_CELLS - 1));
            end
        end else begin
            kind = tcw_pkg::KIND_PUT;
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                char_code = tcw_pkg::CHAR_NEWLINE;
            end else if (pick < 9) begin
                char_code = tcw_pkg::CHAR_RETURN;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        tcw_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("cursor_column",   int'(want.cursor_column),   int'(m_tdata[6:0]));
                check_field("cursor_row",      int'(want.cursor_row),      int'(m_tdata[11:7]));
                check_field("cursor_position", int'(want.cursor_position), int'(m_tdata[22:12]));
                check_field("read_char",       int'(want.read_char),       int'(m_tdata[30:23]));
                check_field("read_attribute",  int'(want.read_attribute),  int'(m_tdata[38:31]));
                check_field("scrolled",        int'(want.scrolled),        int'(m_tuser));
            end
        end
    end

    initial begin
        logic [tcw_pkg::KIND_W-1:0]  kind;
        logic [tcw_pkg::CHAR_W-1:0]  char_code;
        logic [tcw_pkg::INDEX_W-1:0] cell_index;
        logic [tcw_pkg::ATTR_W-1:0]  phase_attr [4];
        int                          phase_idle [4];
        int                          phase_stall [4];

        blank_screen();
        cursor_col  = '0;
        cursor_row  = '0;
        attr_shadow = tcw_pkg::ATTR_DEFAULT;

        // hand-worked rows run under the reset attribute
        add_row(tcw_pkg::KIND_READ,  0,    0,    1, 0, 0, 0,   8'h20, 8'h0F);
        add_row(tcw_pkg::KIND_READ,  0,    1999, 1, 0, 0, 0,   8'h20, 8'h0F);
        add_row(tcw_pkg::KIND_READ,  0,    2000, 1, 0, 0, 0,   0,     0);
        add_row(tcw_pkg::KIND_READ,  255,  2047, 1, 0, 0, 0,   0,     0);
        add_row(KIND_UNUSED,         255,  2047, 1, 0, 0, 0,   0,     0);
        add_row(tcw_pkg::KIND_PUT,   8'h41, 0,   1, 1, 0, 1,   0,     0);
        add_row(tcw_pkg::KIND_PUT,   8'h00, 0,   1, 2, 0, 2,   0,     0);
        add_row(tcw_pkg::KIND_PUT,   8'hFF, 2047, 1, 3, 0, 3,  0,     0);
        add_row(tcw_pkg::KIND_READ,  0,    0,    1, 3, 0, 3,   8'h41, 8'h0F);
        add_row(tcw_pkg::KIND_READ,  0,    2,    1, 3, 0, 3,   8'hFF, 8'h0F);
        add_row(tcw_pkg::KIND_PUT,   tcw_pkg::CHAR_RETURN,  0, 1, 0, 0, 0,   0, 0);
        add_row(tcw_pkg::KIND_PUT,   tcw_pkg::CHAR_NEWLINE, 0, 1, 0, 1, 80,  0, 0);
        add_row(tcw_pkg::KIND_PUT,   tcw_pkg::CHAR_NEWLINE, 0, 1, 0, 2, 160, 0, 0);
        add_row(tcw_pkg::KIND_PUT,   8'h7E, 0,   1, 1, 2, 161, 0,     0);
        add_row(tcw_pkg::KIND_READ,  0,    160,  0, 0, 0, 0,   0,     0);
        add_row(tcw_pkg::KIND_CLEAR, 255,  2047, 1, 0, 0, 0,   0,     0);
        add_row(tcw_pkg::KIND_READ,  0,    160,  1, 0, 0, 0,   8'h20, 8'h0F);
        add_row(tcw_pkg::KIND_PUT,   8'h55, 11'h555, 0, 0, 0, 0, 0,   0);
        add_row(tcw_pkg::KIND_PUT,   8'hAA, 11'h2AA, 0, 0, 0, 0, 0,   0);
        add_row(tcw_pkg::KIND_READ,  0,    1,    0, 0, 0, 0,   0,     0);
        add_row(KIND_UNUSED,         0,    0,    0, 0, 0, 0,   0,     0);

        phase_attr[0] = 8'h00;
        phase_attr[1] = 8'hFF;
        phase_attr[2] = tcw_pkg::ATTR_W'($urandom_range(0, 255));
        phase_attr[3] = tcw_pkg::ATTR_W'($urandom_range(0, 255));
        phase_idle    = '{0, 64, 0, 23};
        phase_stall   = '{0, 0, 64, 23};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].kind, directed_rows[i].char_code,
                         directed_rows[i].cell_index, directed_rows[i].hand_worked,
                         directed_rows[i].want);
        end

        for (int p = 0; p < 4; p++) begin
            s_tvalid <= 1'b0;
            wait_drained();
            sender_idle_pct    = phase_idle[p];
            receiver_stall_pct = phase_stall[p];
            write_attribute(phase_attr[p]);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                random_request(kind, char_code, cell_index);
                send_request(kind, char_code, cell_index, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== text_console_writer.f =====
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_screen_ram.sv
sv/tcw_ctrl.sv
sv/text_console_writer.sv
sv/tcw_checker.sv
tb/text_console_writer_test.sv
